// ===== hw/rtl/gavp_pkg.sv =====
`timescale 1ns / 1ps
package gavp_pkg;
  localparam int ROW_CELLS = 64;
  localparam int COL_W = $clog2(ROW_CELLS);
  localparam int CNT_W = COL_W + 1;
  localparam int QUEUE_DEPTH = 2;
  localparam logic [15:0] FIX_055 = 16'd36045;
  localparam logic [15:0] FIX_050 = 16'd32768;

  localparam logic [1:0] REG_WIDTH = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_STEP = 2'd2;

  // one finished row handed from the loader to the row engine
  typedef struct packed {
    logic [CNT_W-1:0] width;
    logic             polar;
    logic [COL_W-1:0] bank;
  } row_job_t;

  typedef struct packed {
    logic [31:0] new_east_west;
    logic [31:0] new_north_south;
    logic [31:0] cell_convergence;
    logic [31:0] updated_pressure;
    logic        row_last;
  } result_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    logic [31:0] r;
    if (x > 64'sd2147483647) r = 32'h7fffffff;
    else if (x < -64'sd2147483648) r = 32'h80000000;
    else r = x[31:0];
    return r;
  endfunction

  // add half an lsb, then floor by 2^16
  function automatic logic signed [63:0] round16(input logic signed [63:0] p);
    logic signed [63:0] x;
    x = p + 64'sd32768;
    return x >>> 16;
  endfunction
endpackage

// ===== hw/rtl/gavp_row_loader.sv =====
`timescale 1ns / 1ps
module gavp_row_loader
  import gavp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [6:0]       grid_width,
  input  logic [15:0]      grid_height,
  output logic [COL_W-1:0] wr_col,
  output logic             wr_en,
  output logic [COL_W-1:0] wr_bank,
  output logic             job_push,
  output row_job_t         job,
  input  logic             queue_full
);
  logic [CNT_W-1:0] column_count;
  logic [15:0] row_count;
  logic [COL_W-1:0] bank;
  logic [CNT_W-1:0] w;
  logic [CNT_W-1:0] col;
  logic row_end;
  logic [15:0] h;
  logic [15:0] row_next;

  always_comb begin
    if (grid_width == 7'd0) w = CNT_W'(1);
    else if (32'(grid_width) > ROW_CELLS) w = CNT_W'(ROW_CELLS);
    else w = CNT_W'(grid_width);
    col = (column_count >= w) ? w - CNT_W'(1) : column_count;
    row_end = (col + CNT_W'(1)) >= w;
    h = (grid_height == 16'd0) ? 16'd1 : grid_height;
    row_next = row_count + 16'd1;
  end

  // every cell, not only a row end, needs a free queue slot; the engine owns the bank it names
  assign in_ready = !queue_full;
  assign wr_en = in_valid && in_ready;
  assign wr_col = col[COL_W-1:0];
  assign wr_bank = bank;
  assign job_push = wr_en && row_end;
  assign job = '{width: w, polar: (row_count == 16'd0), bank: bank};

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count <= '0;
      bank <= '0;
    end else if (wr_en) begin
      if (row_end) begin
        column_count <= '0;
        row_count <= (row_next >= h) ? 16'd0 : row_next;
        bank <= bank + COL_W'(1);
      end else begin
        column_count <= col + CNT_W'(1);
      end
    end
  end
endmodule

// ===== hw/rtl/gavp_row_engine.sv =====
`timescale 1ns / 1ps
module gavp_row_engine
  import gavp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_write,
  input  logic [COL_W-1:0] in_col,
  input  logic [COL_W-1:0] in_bank,
  input  logic [95:0]      in_cell,
  input  logic             job_push,
  input  row_job_t         job_in,
  output logic             queue_full,
  input  logic [30:0]      time_step,
  output logic             out_valid,
  input  logic             out_ready,
  output result_t          out_data
);
  // two row slots of cell data: bank bit 0 selects the slot
  logic [95:0] cur_mem [2*ROW_CELLS];
  logic [95:0] prev_mem [ROW_CELLS];
  logic [31:0] prev_ns_mem [ROW_CELLS];

  row_job_t q [QUEUE_DEPTH];
  logic [1:0] q_cnt;
  logic q_rd, q_wr;
  row_job_t jb;

  localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_A = 3'd2, S_B = 3'd3,
    S_C = 3'd4, S_D = 3'd5, S_OUT = 3'd6;
  logic [2:0] state;
  logic [CNT_W-1:0] x;
  logic [1:0] phase;
  logic pre;
  logic [COL_W-1:0] rd_addr;
  logic [95:0] rd_data, rd_prev;
  logic [31:0] rd_pns;
  logic [95:0] c_x, c_w, pv;
  logic [31:0] pns;
  logic [31:0] ew_west, ew_x, ns_x;
  logic signed [63:0] s_ew, s_ns, conv_s;
  logic signed [63:0] prod;
  logic [31:0] conv;

  assign queue_full = (q_cnt == 2'(QUEUE_DEPTH));
  assign q_wr = job_push;
  assign jb = q[0];

  always_ff @(posedge clk) begin
    if (in_write) cur_mem[{in_bank[0], in_col}] <= in_cell;
    rd_data <= cur_mem[{jb.bank[0], rd_addr}];
    rd_prev <= prev_mem[rd_addr];
    rd_pns <= prev_ns_mem[rd_addr];
    if (state == S_OUT && out_valid && out_ready) begin
      prev_mem[x[COL_W-1:0]] <= c_x;
      prev_ns_mem[x[COL_W-1:0]] <= ns_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) q_cnt <= '0;
    else begin
      if (q_rd) q[0] <= (q_wr && q_cnt == 2'd1) ? job_in : q[1];
      else if (q_wr) q[q_cnt[0]] <= job_in;
      q_cnt <= q_cnt + 2'(q_wr) - 2'(q_rd);
    end
  end

  always_comb begin
    s_ew = jb.polar ? 64'(signed'(c_x[63:32])) + 64'(signed'(c_x[31:0]))
                      + 64'(signed'(c_w[31:0]))
         : 64'(signed'(c_x[63:32])) + 64'(signed'(pv[63:32]))
           + 64'(signed'(c_x[31:0])) + 64'(signed'(c_w[31:0]));
    s_ns = 64'(signed'(c_x[95:64])) + 64'(signed'(c_w[95:64]))
         + 64'(signed'(c_x[31:0])) - 64'(signed'(pv[31:0]));
    conv_s = 64'(signed'(ew_x)) - 64'(signed'(ew_west));
    if (!jb.polar) conv_s = conv_s + 64'(signed'(ns_x)) - 64'(signed'(pns));
  end

  // a short first pass finds ew of the last column (west of column 0),
  // then per column: read x-1 then x, compute ew/ns, conv, pressure product
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      q_rd <= 1'b0;
    end else begin
      q_rd <= 1'b0;
      case (state)
        S_IDLE: if (q_cnt != '0 && !q_rd) begin
          x <= jb.width - CNT_W'(1);
          pre <= 1'b1;
          phase <= '0;
          rd_addr <= (jb.width == CNT_W'(1)) ? '0 : COL_W'(jb.width - CNT_W'(2));
          state <= S_RD;
        end
        S_RD: begin
          // phase 0: fetch west cell, phase 1: fetch own cell
          phase <= phase + 2'd1;
          if (phase == 2'd0) rd_addr <= x[COL_W-1:0];
          if (phase == 2'd1) c_w <= rd_data;
          if (phase == 2'd2) begin
            c_x <= rd_data; pv <= rd_prev; pns <= rd_pns;
            state <= S_A;
          end
        end
        S_A: begin
          prod <= s_ew * 64'(signed'({1'b0, jb.polar ? FIX_050 : FIX_055}));
          state <= S_B;
        end
        S_B: begin
          if (pre) begin
            ew_west <= sat32(round16(prod));
            pre <= 1'b0;
            x <= '0;
            phase <= '0;
            rd_addr <= COL_W'(jb.width - CNT_W'(1));
            state <= S_RD;
          end else begin
            ew_x <= sat32(round16(prod));
            prod <= s_ns * 64'(signed'({1'b0, FIX_050}));
            state <= S_C;
          end
        end
        S_C: begin
          ns_x <= jb.polar ? 32'd0 : sat32(round16(prod));
          state <= S_D;
        end
        S_D: begin
          conv <= sat32(conv_s);
          state <= S_OUT;
        end
        default: begin
          if (!out_valid) begin
            prod <= 64'(signed'(conv)) * 64'(signed'({1'b0, time_step}));
            out_valid <= 1'b1;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            ew_west <= ew_x;
            if (x + CNT_W'(1) >= jb.width) begin
              state <= S_IDLE; q_rd <= 1'b1;
            end else begin
              x <= x + CNT_W'(1);
              rd_addr <= x[COL_W-1:0];
              phase <= '0;
              state <= S_RD;
            end
          end
        end
      endcase
    end
  end

  assign out_data = '{new_east_west: ew_x, new_north_south: ns_x,
    cell_convergence: conv,
    updated_pressure: sat32(64'(signed'(c_x[31:0])) + round16(prod)),
    row_last: (x + CNT_W'(1) >= jb.width)};
endmodule

// ===== hw/rtl/grid_air_velocity_pressure_step_unit.sv =====
`timescale 1ns / 1ps
// grid air velocity / pressure step
// cells enter on s_axis in raster order, tdata = {old_north_south,
// old_east_west, cell_pressure}. when a row's last cell is taken the row
// goes to a two-entry job queue and the row engine emits one result per
// cell on m_axis, tlast on the last cell of the row.
// the engine starts on a row once its last cell is taken, then works
// through it one cell at a time, reading over one-port row memory and
// sharing one product register; each result waits on m_axis until taken,
// and a stalled m_axis holds the result and the engine.
// input takes one cell a cycle until a finished row waits behind the row
// being emitted; then s_axis_tready drops until that row is done.
// registers over apb: 0x0 grid_width, 0x4 grid_height, 0x8 time_step;
// the user must write them only while idle, the block does not enforce it.
// reset clears counters, queue and registers to 64 / 32 / 1.0.
module grid_air_velocity_pressure_step_unit
  import gavp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // cell_pressure, old_east_west, old_north_south
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // new_east_west, new_north_south, cell_convergence,
                                       // updated_pressure
  output logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  logic [6:0] grid_width;
  logic [15:0] grid_height;
  logic [30:0] time_step;
  logic wr_en, job_push, queue_full;
  logic [COL_W-1:0] wr_col, wr_bank;
  row_job_t job;
  result_t res;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= 7'd64; grid_height <= 16'd32; time_step <= 31'd65536;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_WIDTH: grid_width <= pwdata[6:0];
        REG_HEIGHT: grid_height <= pwdata[15:0];
        REG_STEP: time_step <= pwdata[30:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[3:2])
      REG_WIDTH: prdata = {25'd0, grid_width};
      REG_HEIGHT: prdata = {16'd0, grid_height};
      REG_STEP: prdata = {1'b0, time_step};
      default: prdata = '0;
    endcase
  end

  gavp_row_loader u_load (.clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .grid_width, .grid_height, .wr_col, .wr_en, .wr_bank, .job_push, .job, .queue_full);
  gavp_row_engine u_eng (.clk, .rst, .in_write(wr_en), .in_col(wr_col), .in_bank(wr_bank),
    .in_cell(s_axis_tdata), .job_push, .job_in(job), .queue_full, .time_step,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(res));

  assign m_axis_tdata = {res.updated_pressure, res.cell_convergence,
                         res.new_north_south, res.new_east_west};
  assign m_axis_tlast = res.row_last;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    queue_full |-> !s_axis_tready) else $error("accepted while queue full");
endmodule
